### design/srpg_pkg.sv
package srpg_pkg;

  // fixed field widths
  localparam int unsigned POS_W     = 32;
  localparam int unsigned IVL_W     = 24;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned FIX_W     = 32;
  localparam int unsigned SPR_W     = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // shared serial multiplier and divider
  localparam int unsigned MUL_A_W   = 64;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);
  localparam int unsigned DIV_N_W   = 56;
  localparam int unsigned DIV_D_W   = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  // profile datapath
  localparam int unsigned DV_W   = 37;  // acc*elapsed/1e6 stays below 2^37
  localparam int unsigned VW_W   = 40;  // working velocity before clamping
  localparam int unsigned DIST_W = 50;  // signed distance in step/65536 units
  localparam int unsigned MAG_W  = 49;
  localparam int unsigned CMP_W  = 82;  // braking test products

  // divide by 1e6 = 2^6 * 15625: shift, then multiply by ceil(2^64/15625),
  // exact for shifted values below 2^50; the 50-bit operand goes in two halves
  localparam int unsigned RCP_SH = 6;
  localparam int unsigned NSH_W  = 50;
  localparam int unsigned RLO_W  = 83;   // reciprocal times low half
  localparam int unsigned RSUM_W = 101;  // full reciprocal product
  localparam logic [MUL_A_W-1:0] RCP_15625 = 64'd1180591620717412;

  localparam logic [DIV_N_W-1:0] TICK_SCALE    = 56'd1073741824;
  localparam logic [IVL_W-1:0]   IVL_MAX       = '1;
  localparam logic signed [VW_W-1:0] VEL_HI    = 40'sd2147483647;
  localparam logic signed [VW_W-1:0] VEL_LO    = -40'sd2147483648;

  localparam logic [CFG_W-1:0] RST_MAX_ACC   = 32'd65536;
  localparam logic [CFG_W-1:0] RST_MAX_SPEED = 32'd65536;
  localparam logic [SPR_W-1:0] RST_SPR       = 16'd200;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPR       = 2'd2;

  // mode codes on the input channel
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_TARGET = 2'd2;
  localparam logic [1:0] MODE_TARE   = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_UPDATE,
    OP_TARGET,
    OP_TARE
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [ELAPSED_W-1:0]     elapsed;
    logic signed [FIX_W-1:0]  target;
    logic signed [POS_W-1:0]  tare;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DV,
    ST_RCP_LO,
    ST_RCP_HI,
    ST_MUL_T,
    ST_DECIDE,
    ST_MUL_MA,
    ST_MUL_VV,
    ST_MUL_VS,
    ST_CLAMP,
    ST_MUL_IS,
    ST_DIV_IS,
    ST_MUL_TS
  } back_state_e;

endpackage

### design/stepper_ramp_pulse_generator.sv
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   mode_i, elapsed_us_i, target_rotations_i, tare_steps_i
// output    out_valid_o / out_stall_i step_level_o, step_direction_o, position_steps_o,
//                                     velocity_rps_o, at_target_o
// config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Tick and tare items are done in the idle state, so ticks run one per cycle while the
// result side keeps pace. A drive-to-target item takes one pass of the 32-step
// serial multiplier. A profile update takes up to eight multiplier passes (two
// of them for the divide by 1e6 by reciprocal) and, for a nonzero new speed and
// step count per rotation, one pass of the 56-step divider for the step interval.
// Reset is asynchronous and active low; no clearing pass is needed.
// A two-entry queue parts the front from the sequencer, so input is taken, until
// the queue is full, while the sequencer works or while a result waits on out_stall_i.
module stepper_ramp_pulse_generator import srpg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [ELAPSED_W-1:0]    elapsed_us_i,
  input  logic signed [FIX_W-1:0] target_rotations_i,
  input  logic signed [POS_W-1:0] tare_steps_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    step_level_o,
  output logic                    step_direction_o,
  output logic signed [POS_W-1:0] position_steps_o,
  output logic signed [FIX_W-1:0] velocity_rps_o,
  output logic                    at_target_o
);

  // front to back queue
  logic  q_valid, q_pop;
  item_t q_item;

  // front: takes items, decodes the mode and queues them
  srpg_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .elapsed_us_i       (elapsed_us_i),
    .target_rotations_i (target_rotations_i),
    .tare_steps_i       (tare_steps_i),
    .q_valid_o          (q_valid),
    .q_item_o           (q_item),
    .q_pop_i            (q_pop)
  );

  // back: pulse generator, profile sequencer, result register
  srpg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .step_level_o     (step_level_o),
    .step_direction_o (step_direction_o),
    .position_steps_o (position_steps_o),
    .velocity_rps_o   (velocity_rps_o),
    .at_target_o      (at_target_o)
  );

endmodule

### design/srpg_front.sv
module srpg_front import srpg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [ELAPSED_W-1:0]    elapsed_us_i,
  input  logic signed [FIX_W-1:0] target_rotations_i,
  input  logic signed [POS_W-1:0] tare_steps_i,
  output logic                    q_valid_o,
  output item_t                   q_item_o,
  input  logic                    q_pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  item_t             cls;

  // classify
  always_comb begin
    cls.elapsed = elapsed_us_i;
    cls.target  = target_rotations_i;
    cls.tare    = tare_steps_i;
    case (mode_i)
      MODE_TICK:   cls.op = OP_TICK;
      MODE_UPDATE: cls.op = OP_UPDATE;
      MODE_TARGET: cls.op = OP_TARGET;
      MODE_TARE:   cls.op = OP_TARE;
      default:     cls.op = OP_TICK;
    endcase
  end

  assign in_stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

### design/srpg_mul.sv
module srpg_mul import srpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output unit_status_t       status_o,
  output logic [MUL_P_W-1:0] prod_o
);

  // shift-add, one multiplier bit a cycle
  logic [MUL_A_W-1:0]   a_q, a_d, hi_q, hi_d;
  logic [MUL_B_W-1:0]   lo_q, lo_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [MUL_A_W:0]     sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = MUL_CNT_W'(MUL_B_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MUL_A_W:1];
      lo_d  = {sum[0], lo_q[MUL_B_W-1:1]};
      cnt_d = cnt_q - MUL_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = {hi_q, lo_q};

endmodule

### design/srpg_div.sv
module srpg_div import srpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output unit_status_t       status_o,
  output logic [DIV_N_W-1:0] quot_o
);

  // restoring division, one quotient bit a cycle
  logic [DIV_N_W-1:0]   nq_q, nq_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d, den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_D_W:0]     rem_sh, diff;
  logic                 ge;

  assign rem_sh = {rem_q, nq_q[DIV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DIV_CNT_W'(DIV_N_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      nq_d  = {nq_q[DIV_N_W-2:0], ge};
      rem_d = ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = nq_q;

endmodule

### design/srpg_back.sv
module srpg_back import srpg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    q_valid_i,
  input  item_t                   q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    step_level_o,
  output logic                    step_direction_o,
  output logic signed [POS_W-1:0] position_steps_o,
  output logic signed [FIX_W-1:0] velocity_rps_o,
  output logic                    at_target_o
);

  back_state_e state_q, state_d;
  logic        launched_q, launched_d;

  logic [CFG_W-1:0] acc_q, vmax_q;
  logic [SPR_W-1:0] spr_q;

  logic [POS_W-1:0]        pos_q, pos_d, tgt_q, tgt_d;
  logic signed [FIX_W-1:0] tfix_q, tfix_d, vel_q, vel_d;
  logic [IVL_W-1:0]        ivl_q, ivl_d, tss_q, tss_d;
  logic                    phase_q, phase_d, dir_q, dir_d, line_q, line_d;

  item_t                   item_q, item_d;
  logic [DV_W-1:0]         dv_q, dv_d;
  logic [NSH_W-1:0]        nsh_q, nsh_d;
  logic [RLO_W-1:0]        rlo_q, rlo_d;
  logic signed [VW_W-1:0]  v_q, v_d;
  logic                    dpos_q, dpos_d;
  logic [MAG_W-1:0]        mag_q, mag_d;
  logic [CMP_W-1:0]        pma_q, pma_d;

  logic                    out_valid_q, out_valid_d;
  logic                    o_line_q, o_dir_q, o_at_q;
  logic [POS_W-1:0]        o_pos_q;
  logic [FIX_W-1:0]        o_vel_q;

  logic                    mul_start, div_start, can_start, fin, st_unit;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [MUL_P_W-1:0]      mul_prod;
  logic [DIV_N_W-1:0]      div_n, div_quot;
  logic [DIV_D_W-1:0]      div_d;
  unit_status_t            mul_st, div_st;

  // shared arithmetic units
  srpg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .status_o (mul_st),
    .prod_o   (mul_prod)
  );

  srpg_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_n),
    .den_i    (div_d),
    .status_o (div_st),
    .quot_o   (div_quot)
  );

  assign can_start = q_valid_i && (!out_valid_q || !out_stall_i);

  // speed change: reciprocal times high half added to the stored low half
  logic [RSUM_W-1:0] rcp_sum;
  assign rcp_sum = {mul_prod[RSUM_W-MUL_B_W-1:0], {MUL_B_W{1'b0}}} + RSUM_W'(rlo_q);

  // magnitudes
  logic [FIX_W-1:0] tf_abs, vel_abs, tin_abs;
  assign tf_abs  = tfix_q[FIX_W-1] ? (~tfix_q + FIX_W'(1)) : tfix_q;
  assign vel_abs = vel_q[FIX_W-1] ? (~vel_q + FIX_W'(1)) : vel_q;
  assign tin_abs = item_q.target[FIX_W-1] ? (~item_q.target + FIX_W'(1)) : item_q.target;

  // distance to target: target_fixed*spr - position*65536
  logic signed [DIST_W-1:0] t_dist, p_dist, dd;
  logic                     d_zero, dir_pos, vel_pos, simple;
  logic [MAG_W-1:0]         mag;
  always_comb begin
    t_dist  = tfix_q[FIX_W-1] ? -$signed({2'b00, mul_prod[47:0]})
                              : $signed({2'b00, mul_prod[47:0]});
    p_dist  = $signed({{2{pos_q[POS_W-1]}}, pos_q, 16'h0000});
    dd      = t_dist - p_dist;
    d_zero  = (dd == '0);
    dir_pos = !dd[DIST_W-1];
    mag     = dd[DIST_W-1] ? MAG_W'(-dd) : MAG_W'(dd);
    vel_pos = !vel_q[FIX_W-1] && (vel_q != '0);
    simple  = (vel_q == '0) || (dir_pos != vel_pos);
  end

  // velocity step and clamp
  logic signed [VW_W-1:0] vel_ext, dv_ext, v_plus, v_minus, vc;
  logic [VW_W-1:0]        v_abs, vmax_ext;
  logic signed [FIX_W-1:0] vnew;
  logic                   accel, need_ivl;
  always_comb begin
    vel_ext  = VW_W'(vel_q);
    dv_ext   = $signed(VW_W'(dv_q));
    v_plus   = vel_ext + dv_ext;
    v_minus  = vel_ext - dv_ext;
    accel    = pma_q > mul_prod[CMP_W-1:0];
    v_abs    = v_q[VW_W-1] ? VW_W'(-v_q) : VW_W'(v_q);
    vmax_ext = VW_W'(vmax_q);
    if (v_abs > vmax_ext) begin
      vc = v_q[VW_W-1] ? -$signed(vmax_ext) : $signed(vmax_ext);
    end else begin
      vc = v_q;
    end
    if (vc > VEL_HI) begin
      vnew = FIX_W'(VEL_HI);
    end else if (vc < VEL_LO) begin
      vnew = FIX_W'(VEL_LO);
    end else begin
      vnew = vc[FIX_W-1:0];
    end
    need_ivl = (vnew != '0) && (spr_q != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (can_start) begin
          case (q_item_i.op)
            OP_UPDATE: state_d = ST_MUL_DV;
            OP_TARGET: state_d = ST_MUL_TS;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL_DV: if (mul_st.done) state_d = ST_RCP_LO;
      ST_RCP_LO: if (mul_st.done) state_d = ST_RCP_HI;
      ST_RCP_HI: if (mul_st.done) state_d = ST_MUL_T;
      ST_MUL_T:  if (mul_st.done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = (!d_zero && !simple) ? ST_MUL_MA : ST_CLAMP;
      ST_MUL_MA: if (mul_st.done) state_d = ST_MUL_VV;
      ST_MUL_VV: if (mul_st.done) state_d = ST_MUL_VS;
      ST_MUL_VS: if (mul_st.done) state_d = ST_CLAMP;
      ST_CLAMP:  state_d = need_ivl ? ST_MUL_IS : ST_IDLE;
      ST_MUL_IS: if (mul_st.done) state_d = ST_DIV_IS;
      ST_DIV_IS: if (div_st.done) state_d = ST_IDLE;
      ST_MUL_TS: if (mul_st.done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit control and operands
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_n   = TICK_SCALE;
    div_d   = '0;
    st_unit = 1'b1;
    case (state_q)
      ST_MUL_DV: begin
        mul_a = MUL_A_W'(acc_q);
        mul_b = MUL_B_W'(item_q.elapsed);
      end
      ST_RCP_LO: begin
        mul_a = RCP_15625;
        mul_b = nsh_q[MUL_B_W-1:0];
      end
      ST_RCP_HI: begin
        mul_a = RCP_15625;
        mul_b = MUL_B_W'(nsh_q[NSH_W-1:MUL_B_W]);
      end
      ST_MUL_T: begin
        mul_a = MUL_A_W'(tf_abs);
        mul_b = MUL_B_W'(spr_q);
      end
      ST_MUL_MA: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(acc_q);
      end
      ST_MUL_VV: begin
        mul_a = MUL_A_W'(vel_abs);
        mul_b = MUL_B_W'(vel_abs);
      end
      ST_MUL_VS: begin
        mul_a = mul_prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(spr_q);
      end
      ST_MUL_IS: begin
        mul_a = MUL_A_W'(vel_abs);
        mul_b = MUL_B_W'(spr_q);
      end
      ST_DIV_IS: div_d = mul_prod[DIV_D_W-1:0];
      ST_MUL_TS: begin
        mul_a = MUL_A_W'(tin_abs);
        mul_b = MUL_B_W'(spr_q);
      end
      default: st_unit = 1'b0;
    endcase
    q_pop_o    = (state_q == ST_IDLE) && can_start;
    mul_start  = st_unit && !launched_q && (state_q != ST_DIV_IS);
    div_start  = !launched_q && (state_q == ST_DIV_IS);
    launched_d = st_unit && (state_d == state_q) && (launched_q || mul_start || div_start);
  end

  // tick: two-phase pulse generator
  logic [IVL_W-1:0] tss_inc;
  assign tss_inc = (tss_q < IVL_MAX) ? tss_q + IVL_W'(1) : tss_q;

  // datapath
  logic [31:0] ts_sh;
  always_comb begin
    pos_d       = pos_q;
    tgt_d       = tgt_q;
    tfix_d      = tfix_q;
    vel_d       = vel_q;
    ivl_d       = ivl_q;
    tss_d       = tss_q;
    phase_d     = phase_q;
    dir_d       = dir_q;
    line_d      = line_q;
    item_d      = item_q;
    dv_d        = dv_q;
    nsh_d       = nsh_q;
    rlo_d       = rlo_q;
    v_d         = v_q;
    dpos_d      = dpos_q;
    mag_d       = mag_q;
    pma_d       = pma_q;
    fin         = 1'b0;
    ts_sh       = mul_prod[47:16];
    case (state_q)
      ST_IDLE: begin
        if (can_start) begin
          item_d = q_item_i;
          case (q_item_i.op)
            OP_TICK: begin
              fin = 1'b1;
              if (phase_q) begin
                tss_d = tss_inc;
                if (pos_q != tgt_q) begin
                  if (tss_inc >= ivl_q) begin
                    line_d = 1'b1;
                    pos_d  = dir_q ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
                    tss_d  = '0;
                  end
                  phase_d = 1'b0;
                end
              end else begin
                line_d  = 1'b0;
                phase_d = 1'b1;
              end
            end
            OP_TARE: begin
              fin   = 1'b1;
              pos_d = q_item_i.tare;
            end
            default: ;
          endcase
        end
      end
      ST_MUL_DV: if (mul_st.done) nsh_d = mul_prod[RCP_SH+NSH_W-1:RCP_SH];
      ST_RCP_LO: if (mul_st.done) rlo_d = mul_prod[RLO_W-1:0];
      ST_RCP_HI: if (mul_st.done) dv_d = rcp_sum[RSUM_W-1:MUL_A_W];
      ST_DECIDE: begin
        dpos_d = dir_pos;
        mag_d  = mag;
        if (d_zero) begin
          v_d = '0;
        end else begin
          v_d = dir_pos ? v_plus : v_minus;
        end
      end
      ST_MUL_MA: if (mul_st.done) pma_d = mul_prod[CMP_W-1:0];
      ST_MUL_VS: begin
        if (mul_st.done) begin
          v_d = (accel == dpos_q) ? v_plus : v_minus;
        end
      end
      ST_CLAMP: begin
        vel_d = vnew;
        dir_d = !vnew[FIX_W-1] && (vnew != '0);
        fin   = !need_ivl;
      end
      ST_DIV_IS: begin
        if (div_st.done) begin
          ivl_d = (div_quot > DIV_N_W'(IVL_MAX)) ? IVL_MAX : div_quot[IVL_W-1:0];
          fin   = 1'b1;
        end
      end
      ST_MUL_TS: begin
        if (mul_st.done) begin
          tfix_d = item_q.target;
          tgt_d  = item_q.target[FIX_W-1] ? POS_W'(~ts_sh + 32'd1) : POS_W'(ts_sh);
          fin    = 1'b1;
        end
      end
      default: ;
    endcase
    if (fin) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      acc_q       <= RST_MAX_ACC;
      vmax_q      <= RST_MAX_SPEED;
      spr_q       <= RST_SPR;
      pos_q       <= '0;
      tgt_q       <= '0;
      tfix_q      <= '0;
      vel_q       <= '0;
      ivl_q       <= IVL_MAX;
      tss_q       <= '0;
      phase_q     <= 1'b0;
      dir_q       <= 1'b0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      pos_q       <= pos_d;
      tgt_q       <= tgt_d;
      tfix_q      <= tfix_d;
      vel_q       <= vel_d;
      ivl_q       <= ivl_d;
      tss_q       <= tss_d;
      phase_q     <= phase_d;
      dir_q       <= dir_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_ACC:   acc_q  <= cfg_data_i;
          CFG_MAX_SPEED: vmax_q <= cfg_data_i;
          CFG_SPR:       spr_q  <= cfg_data_i[SPR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    dv_q   <= dv_d;
    nsh_q  <= nsh_d;
    rlo_q  <= rlo_d;
    v_q    <= v_d;
    dpos_q <= dpos_d;
    mag_q  <= mag_d;
    pma_q  <= pma_d;
    if (fin) begin
      o_line_q <= line_d;
      o_dir_q  <= dir_d;
      o_pos_q  <= pos_d;
      o_vel_q  <= vel_d;
      o_at_q   <= (pos_d == tgt_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_level_o     = o_line_q;
  assign step_direction_o = o_dir_q;
  assign position_steps_o = o_pos_q;
  assign velocity_rps_o   = o_vel_q;
  assign at_target_o      = o_at_q;

`ifndef SYNTHESIS
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy) else $error("multiplier restarted while busy");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE)) else $error("item taken while busy");
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> (!out_valid_q || !out_stall_i)) else $error("result overwrites a held item");
`endif

endmodule
